// ===== design/pdd_pkg.sv =====
// Package for the point distance dedup block: sizes, the stored point type,
// the scan state encoding and the status passed back by the distance unit.
// No dependencies.
package pdd_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 24;
  localparam int TOL_BITS   = 23;
  localparam int KIDX_BITS  = 11;
  localparam int ADDR_BITS  = $clog2(MAX_POINTS);
  localparam int SQ_BITS    = 2 * TOL_BITS;
  localparam int SUM_BITS   = SQ_BITS + 2;

  localparam logic [KIDX_BITS-1:0] MAX_COUNT = KIDX_BITS'(MAX_POINTS);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] z;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } point_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic busy;  // a compare is still in the pipe
    logic hit;   // stored point closer than tolerance
  } dist_status_t;

endpackage

// ===== design/pdd_dist.sv =====
// Three-stage distance check of the current point against one stored point
// per cycle. Flags a hit when the squared distance is below tolerance squared.
// Depends on pdd_pkg.
module pdd_dist import pdd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                issue,     // memory read launched this cycle
  input  point_t              rd_point,  // registered memory read data
  input  point_t              cur_point,
  input  logic [TOL_BITS-1:0] tolerance,
  input  logic [SQ_BITS-1:0]  tol_sq,
  output dist_status_t        status
);

  logic                  v0;
  logic                  v1;
  logic                  v2;
  logic [COORD_BITS-1:0] d1 [3];
  logic                  far1;
  logic [SQ_BITS-1:0]    sq2 [3];
  logic                  far2;
  logic [COORD_BITS-1:0] dabs [3];
  logic                  far_now;
  logic [SUM_BITS-1:0]   sum2;
  logic                  hit;

  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] d;
    d = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
    if (d[COORD_BITS]) begin
      d = -d;
    end
    return d[COORD_BITS-1:0];
  endfunction

  always_comb begin
    dabs[0] = abs_diff(cur_point.x, rd_point.x);
    dabs[1] = abs_diff(cur_point.y, rd_point.y);
    dabs[2] = abs_diff(cur_point.z, rd_point.z);
    far_now = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (dabs[i] >= COORD_BITS'(tolerance)) begin
        far_now = 1'b1;
      end
    end
  end

  // Squares only matter when every axis gap is below tolerance, so 23 bits.
  always_ff @(posedge clk) begin
    d1   <= dabs;
    far1 <= far_now;
    for (int i = 0; i < 3; i++) begin
      sq2[i] <= d1[i][TOL_BITS-1:0] * d1[i][TOL_BITS-1:0];
    end
    far2 <= far1;
  end

  assign sum2 = SUM_BITS'(sq2[0]) + SUM_BITS'(sq2[1]) + SUM_BITS'(sq2[2]);
  assign hit  = v2 && !far2 && (sum2 < SUM_BITS'(tol_sq));

  always_ff @(posedge clk) begin
    if (rst || hit) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= issue;
      v1 <= v0;
      v2 <= v1;
    end
  end

  assign status.busy = v0 || v1 || v2;
  assign status.hit  = hit;

endmodule

// ===== design/point_distance_dedup_core.sv =====
// Greedy distance-threshold point dedup: top level with the point store.
// One point in flight: the next input is accepted only once the previous one
// has been handed to the output; the scan ends early when a close point is
// found. The scan is bound by the store read port.
// Reset (rst, synchronous): store empty, tolerance 0, no result pending.
// Store contents are not cleared; only entries below the count are read.
module point_distance_dedup_core import pdd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [71:0]         s_axis_tdata,   // point_x, point_y, point_z
  input  logic [0:0]          s_axis_tuser,   // set_start
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [87:0]         m_axis_tdata,   // kept_index, out_x, out_y, out_z, zero pad
  output logic [1:0]          m_axis_tuser,   // kept, store_full
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TOL_BITS-1:0] cfg_data        // tolerance
);

  state_t                 state;
  state_t                 state_next;
  logic [KIDX_BITS-1:0]   count;
  logic [KIDX_BITS-1:0]   scan_addr;
  point_t                 cur;
  logic [TOL_BITS-1:0]    tolerance;
  logic [SQ_BITS-1:0]     tol_sq;
  logic                   keep;
  point_t                 mem [MAX_POINTS];
  point_t                 rd_point;
  logic                   issue;
  logic                   out_free;
  logic                   finish;
  logic                   mem_we;
  logic                   in_acc;
  dist_status_t           st;

  logic                   out_kept;
  logic                   out_full;
  logic [KIDX_BITS-1:0]   out_index;
  point_t                 out_point;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= '0;
    end else if (cfg_valid) begin
      tolerance <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    tol_sq <= tolerance * tolerance;
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign issue         = (state == ST_SCAN) && (scan_addr != count) && !st.hit;
  assign finish        = (state == ST_FINISH) && out_free;
  assign mem_we        = finish && keep && (count != MAX_COUNT);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (st.hit || ((scan_addr == count) && !st.busy)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      scan_addr <= '0;
      keep      <= 1'b1;
    end else begin
      if (in_acc) begin
        cur       <= s_axis_tdata;
        scan_addr <= '0;
        keep      <= 1'b1;
        if (s_axis_tuser[0]) begin
          count <= '0;
        end
      end
      if (issue) begin
        scan_addr <= scan_addr + KIDX_BITS'(1);
      end
      if (st.hit) begin
        keep <= 1'b0;
      end
      if (mem_we) begin
        count <= count + KIDX_BITS'(1);
      end
    end
  end

  // Point store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[ADDR_BITS-1:0]] <= cur;
    end
    rd_point <= mem[scan_addr[ADDR_BITS-1:0]];
  end

  pdd_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .rd_point  (rd_point),
    .cur_point (cur),
    .tolerance (tolerance),
    .tol_sq    (tol_sq),
    .status    (st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_kept  <= keep;
      out_full  <= keep && (count == MAX_COUNT);
      out_index <= mem_we ? count + KIDX_BITS'(1) : count;
      out_point <= cur;
    end
  end

  assign m_axis_tuser = {out_full, out_kept};
  assign m_axis_tdata = {5'b0, out_point, out_index};

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_COUNT) else $error("point count beyond store depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_addr <= count)) else $error("scan past count");

  a_hit_in_scan: assert property (@(posedge clk) disable iff (rst)
    st.hit |-> (state == ST_SCAN)) else $error("compare hit outside scan");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (count != '0) && !st.busy) else $error("bad store write");

endmodule
